// File: design/apu_ctl_pkg.sv
// Package for the sound unit control sequencer: transaction types, event codes,
// state structs and the length table. No dependencies.
package apu_ctl_pkg;

  typedef enum logic [1:0] {
    MODE_CHAN_WRITE   = 2'd0,
    MODE_STATUS_WRITE = 2'd1,
    MODE_FRAME_WRITE  = 2'd2,
    MODE_SEQ_TICK     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_SWEEP   = 2'd1,
    REG_PERIOD_LO = 2'd2,
    REG_PERIOD_HI = 2'd3
  } reg_sel_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] reg_index;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pulse1_period;
    logic [10:0] pulse2_period;
    logic [3:0]  pulse1_volume;
    logic [3:0]  pulse2_volume;
    logic [3:0]  noise_volume;
    logic [6:0]  triangle_linear_count;
    logic [3:0]  length_active_mask;
    logic [3:0]  enabled_mask;
    logic [1:0]  pulse_mute_mask;
    logic        triangle_running;
    logic [1:0]  phase_reset_mask;
  } out_item_t;

  // Classified command passed from the front part to the back part.
  typedef struct packed {
    mode_t      mode;
    logic [3:0] reg_index;
    logic [7:0] value;
    logic       quarter;
    logic       half;
    logic [1:0] phase;
  } cmd_t;

  localparam int unsigned QDEPTH = 2;
  localparam logic [10:0] PERIOD_MAX = 11'h7FF;
  localparam logic [7:0]  BIT_LOOP   = 8'h20;
  localparam logic [7:0]  BIT_HALT_T = 8'h80;
  localparam logic [7:0]  BIT_CONST  = 8'h10;
  localparam logic [7:0]  BIT_NEG    = 8'h08;
  localparam logic [3:0]  LEVEL_MAX  = 4'd15;

  function automatic logic [7:0] len_lookup(input logic [4:0] idx);
    logic [7:0] r;
    begin
      unique case (idx)
        5'd0: r = 8'd10;   5'd1: r = 8'd254;  5'd2: r = 8'd20;   5'd3: r = 8'd2;
        5'd4: r = 8'd40;   5'd5: r = 8'd4;    5'd6: r = 8'd80;   5'd7: r = 8'd6;
        5'd8: r = 8'd160;  5'd9: r = 8'd8;    5'd10: r = 8'd60;  5'd11: r = 8'd10;
        5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
        5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
        5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
        5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
        5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
      endcase
      return r;
    end
  endfunction

  // Sweep target, 12 bits so that overflow past the 11-bit range is visible.
  function automatic logic [11:0] sweep_target(input logic [10:0] per,
                                               input logic [7:0] swp,
                                               input logic ones_comp);
    logic [11:0] chg;
    logic [11:0] sub;
    begin
      chg = {1'b0, per >> swp[2:0]};
      if ((swp & BIT_NEG) != 8'h00) begin
        sub = chg + {11'd0, ones_comp};
        return (sub > {1'b0, per}) ? 12'd0 : ({1'b0, per} - sub);
      end
      return {1'b0, per} + chg;
    end
  endfunction

  function automatic logic pulse_muted(input logic [10:0] per, input logic [7:0] swp,
                                       input logic ones_comp);
    return (per < 11'd8) || (sweep_target(per, swp, ones_comp) > {1'b0, PERIOD_MAX});
  endfunction

endpackage

// File: design/apu_channel_control_sequencer.sv
// Top level of the sound unit control sequencer: front classifier, command
// queue and back executor. Uses apu_ctl_pkg and the apu_ctl_* modules.
//
// One result transaction follows every input transaction, in order. The block
// accepts one item per cycle while in_stall is low: the front part classifies
// it and tracks the frame sequencer step, a two-entry queue decouples it from
// the back part, and the back part updates the channel state and registers
// the result. in_stall rises only when the queue is full, which happens only
// while out_stall holds results back.
module apu_channel_control_sequencer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  apu_ctl_pkg::in_item_t  in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output apu_ctl_pkg::out_item_t out_data,
  input  logic                   out_stall
);
  logic              f_valid, q_full, q_valid, q_take;
  apu_ctl_pkg::cmd_t f_cmd, q_cmd;

  apu_ctl_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(in_data),
    .in_stall(in_stall), .cmd_valid(f_valid), .cmd_data(f_cmd), .cmd_full(q_full)
  );

  apu_ctl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_data(f_cmd), .full(q_full),
    .rd_valid(q_valid), .rd_data(q_cmd), .rd_take(q_take)
  );

  apu_ctl_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_data(q_cmd), .cmd_take(q_take),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  // A stalled result must stay in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Queue never takes an item while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(f_valid && q_full))
    else $error("queue overflow");

  // Input is only stalled while results are blocked downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_stall))
    else $error("input stalled without output back-pressure");
endmodule

// File: design/apu_ctl_front.sv
// Front part: accepts transactions, tracks the frame sequencer step and
// classifies each item into a command for the back part. Uses apu_ctl_pkg.
module apu_ctl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  apu_ctl_pkg::in_item_t in_data,
  output logic                 in_stall,
  output logic                 cmd_valid,
  output apu_ctl_pkg::cmd_t    cmd_data,
  input  logic                 cmd_full
);
  logic       five_r, five_nxt;
  logic [2:0] step_r, step_nxt;
  logic       take;
  logic [2:0] limit;
  logic [2:0] s_inc;

  assign in_stall  = cmd_full;
  assign take      = in_valid && !cmd_full;
  assign cmd_valid = take;
  assign limit     = five_r ? 3'd5 : 3'd4;
  assign s_inc     = step_r + 3'd1;

  always_comb begin
    five_nxt = five_r;
    step_nxt = step_r;
    cmd_data.mode      = apu_ctl_pkg::mode_t'(in_data.mode);
    cmd_data.reg_index = in_data.reg_index;
    cmd_data.value     = in_data.value;
    cmd_data.quarter   = 1'b0;
    cmd_data.half      = 1'b0;
    cmd_data.phase     = 2'b00;
    unique case (apu_ctl_pkg::mode_t'(in_data.mode))
      apu_ctl_pkg::MODE_CHAN_WRITE: begin
        if (in_data.reg_index == 4'd3) cmd_data.phase = 2'b01;
        else if (in_data.reg_index == 4'd7) cmd_data.phase = 2'b10;
      end
      apu_ctl_pkg::MODE_STATUS_WRITE: ;
      apu_ctl_pkg::MODE_FRAME_WRITE: begin
        five_nxt = in_data.value[7];
        step_nxt = 3'd0;
        cmd_data.quarter = in_data.value[7];
        cmd_data.half    = in_data.value[7];
      end
      default: begin
        if (step_r < limit) begin
          if (!five_r) begin
            cmd_data.quarter = 1'b1;
            cmd_data.half    = (step_r == 3'd1) || (step_r == 3'd3);
          end else begin
            cmd_data.quarter = (step_r != 3'd3);
            cmd_data.half    = (step_r == 3'd1) || (step_r == 3'd4);
          end
        end
        step_nxt = (s_inc >= limit) ? 3'd0 : s_inc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      five_r <= 1'b0;
      step_r <= 3'd0;
    end else if (take) begin
      five_r <= five_nxt;
      step_r <= step_nxt;
    end
  end
endmodule

// File: design/apu_ctl_queue.sv
// Two-entry command queue between front and back parts. Uses apu_ctl_pkg.
module apu_ctl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  apu_ctl_pkg::cmd_t wr_data,
  output logic              full,
  output logic              rd_valid,
  output apu_ctl_pkg::cmd_t rd_data,
  input  logic              rd_take
);
  apu_ctl_pkg::cmd_t mem_r [apu_ctl_pkg::QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'(apu_ctl_pkg::QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid) wp_r <= ~wp_r;
      if (rd_take)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid} - {1'b0, rd_take};
    end
  end
endmodule

// File: design/apu_ctl_back.sv
// Back part: applies commands to the channel state and registers one result
// per command in an output register. Uses apu_ctl_pkg.
module apu_ctl_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  apu_ctl_pkg::cmd_t      cmd_data,
  output logic                   cmd_take,
  output logic                   out_valid,
  output apu_ctl_pkg::out_item_t out_data,
  input  logic                   out_stall
);
  logic [7:0]  ctl_r [4];
  logic [7:0]  swp_r [2];
  logic [10:0] per_r [2];
  logic [7:0]  len_r [4];
  logic [3:0]  en_r;
  logic [3:0]  elv_r [3];
  logic [3:0]  edv_r [3];
  logic [2:0]  est_r;
  logic [2:0]  sdv_r [2];
  logic [1:0]  srl_r;
  logic [6:0]  lin_r;
  logic        lrl_r;

  logic [7:0]  ctl_nxt [4];
  logic [7:0]  swp_nxt [2];
  logic [10:0] per_nxt [2];
  logic [7:0]  len_nxt [4];
  logic [3:0]  en_nxt;
  logic [3:0]  elv_nxt [3];
  logic [3:0]  edv_nxt [3];
  logic [2:0]  est_nxt;
  logic [2:0]  sdv_nxt [2];
  logic [1:0]  srl_nxt;
  logic [6:0]  lin_nxt;
  logic        lrl_nxt;

  logic                   ov_r;
  apu_ctl_pkg::out_item_t od_r, od_nxt;
  logic [1:0]  ch;
  logic [7:0]  v;
  logic        fire;
  logic [1:0]  echan [3];
  logic [11:0] tgt;
  logic [3:0]  vol [3];

  assign cmd_take  = cmd_valid && (!ov_r || !out_stall);
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign echan[0] = 2'd0;
  assign echan[1] = 2'd1;
  assign echan[2] = 2'd3;

  always_comb begin
    ctl_nxt = ctl_r; swp_nxt = swp_r; per_nxt = per_r; len_nxt = len_r;
    en_nxt = en_r; elv_nxt = elv_r; edv_nxt = edv_r; est_nxt = est_r;
    sdv_nxt = sdv_r; srl_nxt = srl_r; lin_nxt = lin_r; lrl_nxt = lrl_r;
    ch = cmd_data.reg_index[3:2];
    v  = cmd_data.value;
    fire = 1'b0;
    tgt = 12'd0;
    unique case (cmd_data.mode)
      apu_ctl_pkg::MODE_CHAN_WRITE: begin
        unique case (apu_ctl_pkg::reg_sel_t'(cmd_data.reg_index[1:0]))
          apu_ctl_pkg::REG_CONTROL: ctl_nxt[ch] = v;
          apu_ctl_pkg::REG_SWEEP: if (!ch[1]) begin
            swp_nxt[ch[0]] = v;
            srl_nxt[ch[0]] = 1'b1;
          end
          apu_ctl_pkg::REG_PERIOD_LO: if (!ch[1]) per_nxt[ch[0]] = {per_r[ch[0]][10:8], v};
          default: begin
            if (!ch[1]) begin
              per_nxt[ch[0]] = {v[2:0], per_r[ch[0]][7:0]};
              est_nxt[ch[0]] = 1'b1;
            end else if (ch == 2'd2) lrl_nxt = 1'b1;
            else est_nxt[2] = 1'b1;
            if (en_r[ch]) len_nxt[ch] = apu_ctl_pkg::len_lookup(v[7:3]);
          end
        endcase
      end
      apu_ctl_pkg::MODE_STATUS_WRITE: begin
        en_nxt = v[3:0];
        for (int i = 0; i < 4; i++) if (!v[i]) len_nxt[i] = 8'd0;
      end
      default: begin
        if (cmd_data.quarter) begin
          for (int e = 0; e < 3; e++) begin
            if (est_r[e]) begin
              est_nxt[e] = 1'b0;
              elv_nxt[e] = apu_ctl_pkg::LEVEL_MAX;
              edv_nxt[e] = ctl_r[echan[e]][3:0];
            end else if (edv_r[e] != 4'd0) begin
              edv_nxt[e] = edv_r[e] - 4'd1;
            end else begin
              edv_nxt[e] = ctl_r[echan[e]][3:0];
              if (elv_r[e] != 4'd0) elv_nxt[e] = elv_r[e] - 4'd1;
              else if ((ctl_r[echan[e]] & apu_ctl_pkg::BIT_LOOP) != 8'h00)
                elv_nxt[e] = apu_ctl_pkg::LEVEL_MAX;
            end
          end
          if (lrl_r) begin
            lin_nxt = ctl_r[2][6:0];
            if (!ctl_r[2][7]) lrl_nxt = 1'b0;
          end else if (lin_r != 7'd0) lin_nxt = lin_r - 7'd1;
        end
        if (cmd_data.half) begin
          for (int i = 0; i < 4; i++) begin
            if (!((i == 2) ? ctl_r[i][7] : ctl_r[i][5]) && len_r[i] != 8'd0)
              len_nxt[i] = len_r[i] - 8'd1;
          end
          for (int p = 0; p < 2; p++) begin
            fire = 1'b0;
            if (srl_r[p]) begin
              fire = (sdv_r[p] == 3'd0) && swp_r[p][7] && (swp_r[p][2:0] != 3'd0);
              sdv_nxt[p] = swp_r[p][6:4];
              srl_nxt[p] = 1'b0;
            end else if (sdv_r[p] != 3'd0) begin
              sdv_nxt[p] = sdv_r[p] - 3'd1;
            end else begin
              sdv_nxt[p] = swp_r[p][6:4];
              fire = swp_r[p][7] && (swp_r[p][2:0] != 3'd0);
            end
            tgt = apu_ctl_pkg::sweep_target(per_r[p], swp_r[p], p == 0);
            if (fire && !apu_ctl_pkg::pulse_muted(per_r[p], swp_r[p], p == 0))
              per_nxt[p] = tgt[10:0];
          end
        end
      end
    endcase

    for (int e = 0; e < 3; e++)
      vol[e] = ctl_nxt[echan[e]][4] ? ctl_nxt[echan[e]][3:0] : elv_nxt[e];
    od_nxt.pulse1_period = per_nxt[0];
    od_nxt.pulse2_period = per_nxt[1];
    od_nxt.pulse1_volume = vol[0];
    od_nxt.pulse2_volume = vol[1];
    od_nxt.noise_volume  = vol[2];
    od_nxt.triangle_linear_count = lin_nxt;
    for (int i = 0; i < 4; i++) od_nxt.length_active_mask[i] = (len_nxt[i] != 8'd0);
    od_nxt.enabled_mask = en_nxt;
    od_nxt.pulse_mute_mask = {apu_ctl_pkg::pulse_muted(per_nxt[1], swp_nxt[1], 1'b0),
                              apu_ctl_pkg::pulse_muted(per_nxt[0], swp_nxt[0], 1'b1)};
    od_nxt.triangle_running = (lin_nxt != 7'd0) && (len_nxt[2] != 8'd0);
    od_nxt.phase_reset_mask = cmd_data.phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin ctl_r[i] <= 8'd0; len_r[i] <= 8'd0; end
      for (int i = 0; i < 3; i++) begin elv_r[i] <= 4'd0; edv_r[i] <= 4'd0; end
      for (int i = 0; i < 2; i++) begin
        swp_r[i] <= 8'd0; per_r[i] <= 11'd0; sdv_r[i] <= 3'd0;
      end
      en_r <= 4'd0; est_r <= 3'd0; srl_r <= 2'd0; lin_r <= 7'd0; lrl_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cmd_take) begin
        ctl_r <= ctl_nxt; swp_r <= swp_nxt; per_r <= per_nxt; len_r <= len_nxt;
        en_r <= en_nxt; elv_r <= elv_nxt; edv_r <= edv_nxt; est_r <= est_nxt;
        sdv_r <= sdv_nxt; srl_r <= srl_nxt; lin_r <= lin_nxt; lrl_r <= lrl_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) od_r <= od_nxt;
  end
endmodule
